// ===== sv/mtp_pkg.sv =====
`default_nettype none

package mtp_pkg;

   localparam int unsigned STATE_DEPTH  = 624;
   localparam int unsigned IDX_WIDTH    = $clog2(STATE_DEPTH);
   localparam int unsigned WORD_WIDTH   = 32;
   localparam int unsigned TWIST_OFFSET = 397;

   localparam logic [WORD_WIDTH-1:0] INIT_MULT    = 32'h6c078965;
   localparam logic [WORD_WIDTH-1:0] TWIST_MATRIX = 32'h9908b0df;
   localparam logic [WORD_WIDTH-1:0] TEMPER_B     = 32'h9d2c5680;
   localparam logic [WORD_WIDTH-1:0] TEMPER_C     = 32'hefc60000;
   localparam logic [WORD_WIDTH-1:0] UPPER_BIT    = 32'h80000000;
   localparam logic [WORD_WIDTH-1:0] LOWER_BITS   = 32'h7fffffff;

   localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(STATE_DEPTH - 1);

   localparam logic REQ_DRAW = 1'b0;
   localparam logic REQ_SEED = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TWIST,
      ST_SEED
   } state_type;

   typedef struct packed {
      logic                  wr_en;
      logic [IDX_WIDTH-1:0]  wr_addr;
      logic [WORD_WIDTH-1:0] wr_data;
      logic                  rd_en;
      logic [IDX_WIDTH-1:0]  rd_addr_a;
      logic [IDX_WIDTH-1:0]  rd_addr_b;
   } ram_req_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] rd_data_a;
      logic [WORD_WIDTH-1:0] rd_data_b;
   } ram_rsp_type;

   function automatic logic [WORD_WIDTH-1:0] temper(input logic [WORD_WIDTH-1:0] x);
      logic [WORD_WIDTH-1:0] y;
      y = x;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

`default_nettype wire

// ===== sv/mtp_if.sv =====
`default_nettype none

interface mtp_req_if;
   import mtp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [WORD_WIDTH-1:0] seed_value;

   modport source (output valid, output req_type, output seed_value, input ready);
   modport sink   (input valid, input req_type, input seed_value, output ready);
endinterface

interface mtp_rsp_if;
   import mtp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

// ===== sv/mtp_state_ram.sv =====
`default_nettype none

module mtp_state_ram
   import mtp_pkg::*;
(
   input  wire logic        clock,
   input  wire ram_req_type ram_req,
   output ram_rsp_type      ram_rsp
);

   logic [WORD_WIDTH-1:0] mem [STATE_DEPTH];
   logic [WORD_WIDTH-1:0] rd_a_ff;
   logic [WORD_WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_a_ff <= mem[ram_req.rd_addr_a];
         rd_b_ff <= mem[ram_req.rd_addr_b];
      end
   end

   assign ram_rsp.rd_data_a = rd_a_ff;
   assign ram_rsp.rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== sv/mersenne_twister_prng.sv =====
`default_nettype none
// 32-bit mt19937 word generator with 624 words of state in an on-chip ram.
// req_ch carries a request type and a seed word; rsp_ch returns one tempered
// word for each draw request. a seed request returns nothing.
// a draw reads the state ram at the next and far entries through its registered
// read port, then the twisted word is written back at the read index and the
// tempered result is loaded into the output register. a new request is taken
// only once the draw has finished and the block is idle again.
// a seed writes one state word a cycle through the single initialisation
// multiplier, ram write port busy throughout; req_ch.ready is low meanwhile.
// reset clears the read index and marks the state as unseeded; the ram is
// not swept, since every draw before the first seed returns zero without
// touching the ram.
// the result waits in the output register while rsp_ch stalls; the next
// request is still taken, and a draw then holds in its write-back step until
// the output register frees.
module mersenne_twister_prng
   import mtp_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   mtp_req_if.sink  req_ch,
   mtp_rsp_if.source rsp_ch
);

   state_type             state_ff, state_in;
   logic [IDX_WIDTH-1:0]  read_index_ff, read_index_in;
   logic [IDX_WIDTH-1:0]  seed_idx_ff, seed_idx_in;
   logic [WORD_WIDTH-1:0] prev_word_ff, prev_word_in;
   logic                  cur_upper_ff, cur_upper_in;
   logic                  seeded_ff, seeded_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0] rsp_word_ff, rsp_word_in;

   ram_req_type ram_req;
   ram_rsp_type ram_rsp;

   logic [IDX_WIDTH-1:0]  nxt_idx;
   logic [IDX_WIDTH:0]    far_sum;
   logic [IDX_WIDTH-1:0]  far_idx;
   logic [WORD_WIDTH-1:0] twist_y;
   logic [WORD_WIDTH-1:0] twist_w;
   logic [WORD_WIDTH-1:0] init_mix;
   logic [WORD_WIDTH-1:0] init_prod;
   logic [WORD_WIDTH-1:0] init_word;
   logic                  accept;
   logic                  draw_done;

   mtp_state_ram u_state_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .ram_rsp (ram_rsp)
   );

   assign accept = req_ch.valid && req_ch.ready;

   // neighbour and far entries of the twist, wrapped round the state
   assign nxt_idx = (read_index_ff == LAST_IDX) ? '0 : read_index_ff + 1'b1;
   assign far_sum = {1'b0, read_index_ff} + (IDX_WIDTH+1)'(TWIST_OFFSET);
   assign far_idx = (far_sum >= (IDX_WIDTH+1)'(STATE_DEPTH)) ?
                    IDX_WIDTH'(far_sum - (IDX_WIDTH+1)'(STATE_DEPTH)) :
                    far_sum[IDX_WIDTH-1:0];

   // upper bit of the current word comes from the neighbour read of the last draw, or from the seed word
   assign twist_y = ({cur_upper_ff, {(WORD_WIDTH-1){1'b0}}} & UPPER_BIT) |
                    (ram_rsp.rd_data_a & LOWER_BITS);
   assign twist_w = ram_rsp.rd_data_b ^ (twist_y >> 1) ^
                    (twist_y[0] ? TWIST_MATRIX : '0);

   assign init_mix  = prev_word_ff ^ (prev_word_ff >> 30);
   assign init_prod = INIT_MULT * init_mix;
   assign init_word = init_prod + WORD_WIDTH'(seed_idx_ff);

   assign draw_done = (state_ff == ST_TWIST) && (!rsp_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         read_index_ff <= '0;
         seeded_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         read_index_ff <= read_index_in;
         seeded_ff     <= seeded_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_idx_ff  <= seed_idx_in;
      prev_word_ff <= prev_word_in;
      cur_upper_ff <= cur_upper_in;
      rsp_word_ff  <= rsp_word_in;
   end

   always_comb begin
      state_in      = state_ff;
      read_index_in = read_index_ff;
      seed_idx_in   = seed_idx_ff;
      prev_word_in  = prev_word_ff;
      cur_upper_in  = cur_upper_ff;
      seeded_in     = seeded_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      req_ch.ready  = 1'b0;

      ram_req.wr_en     = 1'b0;
      ram_req.wr_addr   = read_index_ff;
      ram_req.wr_data   = twist_w;
      ram_req.rd_en     = 1'b0;
      ram_req.rd_addr_a = nxt_idx;
      ram_req.rd_addr_b = far_idx;

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               if (req_ch.req_type == REQ_SEED) begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = '0;
                  ram_req.wr_data = req_ch.seed_value;
                  prev_word_in    = req_ch.seed_value;
                  cur_upper_in    = req_ch.seed_value[WORD_WIDTH-1];
                  seed_idx_in     = IDX_WIDTH'(1);
                  seeded_in       = 1'b1;
                  state_in        = ST_SEED;
               end else begin
                  ram_req.rd_en = seeded_ff;
                  state_in      = ST_TWIST;
               end
            end
         end
         ST_TWIST: begin
            if (draw_done) begin
               ram_req.wr_en = seeded_ff;
               rsp_valid_in  = 1'b1;
               rsp_word_in   = seeded_ff ? temper(twist_w) : '0;
               cur_upper_in  = ram_rsp.rd_data_a[WORD_WIDTH-1];
               read_index_in = nxt_idx;
               state_in      = ST_IDLE;
            end
         end
         ST_SEED: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = seed_idx_ff;
            ram_req.wr_data = init_word;
            prev_word_in    = init_word;
            seed_idx_in     = seed_idx_ff + 1'b1;
            if (seed_idx_ff == LAST_IDX) begin
               read_index_in = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.random_word = rsp_word_ff;

   a_draw_reads: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.req_type == REQ_DRAW) |=> (state_ff == ST_TWIST))
      else $error("draw transfer did not start the twist step");

   a_seed_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEED && seed_idx_ff == LAST_IDX)
      |=> (state_ff == ST_IDLE && read_index_ff == '0))
      else $error("seed fill did not end with read index cleared");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      read_index_ff <= LAST_IDX)
      else $error("read index beyond state depth");

   a_unseeded_zero: assert property (@(posedge clock) disable iff (reset)
      (draw_done && !seeded_ff) |=> (rsp_ch.valid && rsp_ch.random_word == '0))
      else $error("draw before seeding gave a nonzero word");

   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      draw_done |=> (rsp_ch.valid && state_ff == ST_IDLE))
      else $error("completed draw did not load the output register");

endmodule

`default_nettype wire
